FILE: src/assert_macros.svh
// Assertion macros for the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies the consequent in the same cycle.
`define DKQ_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dkq assertion failed");

// Antecedent in this cycle implies the consequent in the next cycle.
`define DKQ_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dkq assertion failed");

`endif

FILE: src/dkq_pkg.sv
`default_nettype none
package dkq_pkg;

    localparam int DEPTH_DEF = 64;

    // Command codes carried by the input beat.
    typedef enum logic [3:0] {
        CMD_ADD       = 4'd0,
        CMD_EXEC_PRI  = 4'd1,
        CMD_EXEC_TIME = 4'd2,
        CMD_NEXT_PRI  = 4'd3,
        CMD_NEXT_TIME = 4'd4,
        CMD_CHG_PRI   = 4'd5,
        CMD_CHG_TIME  = 4'd6,
        CMD_PRT_PRI   = 4'd7,
        CMD_PRT_TIME  = 4'd8
    } t_cmd;

    // Status codes of the result beat.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // One queue entry.
    typedef struct packed {
        logic [6:0]  pri;
        logic [18:0] tim;
        logic [15:0] tag;
    } t_entry;

    // Operation applied to every cell of a chain at once.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INS,
        OP_DEL,
        OP_ROT
    } t_op;

    // What a cell reports as a hit for the topmost-hit search.
    typedef enum logic [1:0] {
        MODE_VALID,
        MODE_KEY,
        MODE_EXACT
    } t_mode;

    typedef struct packed {
        t_op    op;
        t_mode  mode;
        t_entry probe;
    } t_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIND,
        S_DEL,
        S_INS,
        S_PRINT
    } t_state;

endpackage
`default_nettype wire

FILE: src/dkq_in_if.sv
`default_nettype none
interface dkq_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [6:0]  priority_req;
    logic [18:0] time_seconds;
    logic [15:0] tag;
    logic [6:0]  new_priority;
    logic [18:0] new_time;

    modport source (output valid, cmd, priority_req, time_seconds, tag, new_priority,
                    new_time, input ready);
    modport sink (input valid, cmd, priority_req, time_seconds, tag, new_priority,
                  new_time, output ready);
endinterface
`default_nettype wire

FILE: src/dkq_out_if.sv
`default_nettype none
interface dkq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [6:0]  out_priority;
    logic [18:0] out_time;
    logic [15:0] out_tag;
    logic        entry_valid;
    logic        last;

    modport source (output valid, status, out_priority, out_time, out_tag, entry_valid,
                    last, input ready);
    modport sink (input valid, status, out_priority, out_time, out_tag, entry_valid,
                  last, output ready);
endinterface
`default_nettype wire

FILE: src/dual_key_sorted_process_queue.sv
// Results: add, next, exec, empty and full results are registered and can be taken in the cycle
// after the input beat; a key miss is reported from find, a change from insert after find and
// delete, a print from the print state with one result per entry. One command at a time: the next
// beat is taken only in idle (exec returns after delete) and only while the output can take a result.
// Reset: synchronous, active low; clears the entry count, the sequencer and output valid.
// Entry storage is not cleared; cells at or above the count are never reported.
`default_nettype none
`include "assert_macros.svh"
module dual_key_sorted_process_queue #(
    parameter int DEPTH = dkq_pkg::DEPTH_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    dkq_in_if.sink      i_in,
    dkq_out_if.source   o_out
);

    localparam int CW = $clog2(DEPTH + 1);

    dkq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CW-1:0]   r_k, n_k;
    logic            r_src, n_src;
    logic            r_chg, n_chg;
    dkq_pkg::t_entry r_e, n_e;
    logic [6:0]      r_preq, n_preq;
    logic [18:0]     r_treq, n_treq;
    logic [6:0]      r_npri, n_npri;
    logic [18:0]     r_ntim, n_ntim;

    logic            r_ov;
    logic [1:0]      r_ost;
    dkq_pkg::t_entry r_oe;
    logic            r_oev, r_olast;

    dkq_pkg::t_ctl   ctl_p, ctl_t;
    dkq_pkg::t_entry pick_p, pick_t, pick_s, in_e, e2;
    logic            found_p, found_t, found_s;
    logic            can_emit, accept, emit, em_ev, em_last;
    logic [1:0]      em_st;
    dkq_pkg::t_entry em_e;

    dkq_chain #(.DEPTH(DEPTH), .TIME_KEY(1'b0)) u_pri (
        .i_clk(i_clk), .i_ctl(ctl_p), .i_cnt(r_cnt), .o_pick(pick_p), .o_found(found_p)
    );
    dkq_chain #(.DEPTH(DEPTH), .TIME_KEY(1'b1)) u_tim (
        .i_clk(i_clk), .i_ctl(ctl_t), .i_cnt(r_cnt), .o_pick(pick_t), .o_found(found_t)
    );

    assign can_emit = !r_ov || o_out.ready;
    assign accept   = i_in.valid && i_in.ready;
    assign in_e     = '{pri: i_in.priority_req, tim: i_in.time_seconds, tag: i_in.tag};
    assign pick_s   = r_src ? pick_t : pick_p;
    assign found_s  = r_src ? found_t : found_p;
    assign e2       = r_src ? dkq_pkg::t_entry'{pri: r_e.pri, tim: r_ntim, tag: r_e.tag}
                            : dkq_pkg::t_entry'{pri: r_npri, tim: r_e.tim, tag: r_e.tag};

    // Command sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_src   = r_src;
        n_chg   = r_chg;
        n_e     = r_e;
        n_preq  = r_preq;
        n_treq  = r_treq;
        n_npri  = r_npri;
        n_ntim  = r_ntim;
        ctl_p   = '{op: dkq_pkg::OP_HOLD, mode: dkq_pkg::MODE_VALID, probe: in_e};
        ctl_t   = ctl_p;
        i_in.ready = 1'b0;
        emit    = 1'b0;
        em_st   = dkq_pkg::ST_OK;
        em_e    = '0;
        em_ev   = 1'b0;
        em_last = 1'b1;
        case (r_state)
            dkq_pkg::S_IDLE: begin
                i_in.ready = can_emit;
                if (accept) begin
                    case (i_in.cmd)
                        dkq_pkg::CMD_ADD: begin
                            emit = 1'b1;
                            if (r_cnt == CW'(DEPTH)) begin
                                em_st = dkq_pkg::ST_FULL;
                            end else begin
                                ctl_p.op = dkq_pkg::OP_INS;
                                ctl_t.op = dkq_pkg::OP_INS;
                                n_cnt    = r_cnt + 1'b1;
                            end
                        end
                        dkq_pkg::CMD_EXEC_PRI, dkq_pkg::CMD_EXEC_TIME,
                        dkq_pkg::CMD_NEXT_PRI, dkq_pkg::CMD_NEXT_TIME,
                        dkq_pkg::CMD_CHG_PRI, dkq_pkg::CMD_CHG_TIME,
                        dkq_pkg::CMD_PRT_PRI, dkq_pkg::CMD_PRT_TIME: begin
                            n_src  = (i_in.cmd == dkq_pkg::CMD_EXEC_TIME)
                                  || (i_in.cmd == dkq_pkg::CMD_NEXT_TIME)
                                  || (i_in.cmd == dkq_pkg::CMD_CHG_TIME)
                                  || (i_in.cmd == dkq_pkg::CMD_PRT_TIME);
                            n_preq = i_in.priority_req;
                            n_treq = i_in.time_seconds;
                            n_npri = i_in.new_priority;
                            n_ntim = i_in.new_time;
                            if (r_cnt == '0) begin
                                emit  = 1'b1;
                                em_st = dkq_pkg::ST_EMPTY;
                            end else if ((i_in.cmd == dkq_pkg::CMD_CHG_PRI)
                                      || (i_in.cmd == dkq_pkg::CMD_CHG_TIME)) begin
                                n_state = dkq_pkg::S_FIND;
                            end else if ((i_in.cmd == dkq_pkg::CMD_PRT_PRI)
                                      || (i_in.cmd == dkq_pkg::CMD_PRT_TIME)) begin
                                n_k     = '0;
                                n_state = dkq_pkg::S_PRINT;
                            end else begin
                                // Exec and next report the top of the chosen order.
                                emit  = 1'b1;
                                em_ev = 1'b1;
                                em_e  = n_src ? pick_t : pick_p;
                                if ((i_in.cmd == dkq_pkg::CMD_EXEC_PRI)
                                 || (i_in.cmd == dkq_pkg::CMD_EXEC_TIME)) begin
                                    n_e     = em_e;
                                    n_chg   = 1'b0;
                                    n_state = dkq_pkg::S_DEL;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            dkq_pkg::S_FIND: begin
                // Topmost entry whose key equals the old key.
                ctl_p.mode  = dkq_pkg::MODE_KEY;
                ctl_t.mode  = dkq_pkg::MODE_KEY;
                ctl_p.probe = '{pri: r_preq, tim: r_treq, tag: 16'd0};
                ctl_t.probe = ctl_p.probe;
                if (found_s) begin
                    n_e     = pick_s;
                    n_chg   = 1'b1;
                    n_state = dkq_pkg::S_DEL;
                end else if (can_emit) begin
                    emit    = 1'b1;
                    em_st   = dkq_pkg::ST_NOTFOUND;
                    n_state = dkq_pkg::S_IDLE;
                end
            end
            dkq_pkg::S_DEL: begin
                ctl_p   = '{op: dkq_pkg::OP_DEL, mode: dkq_pkg::MODE_EXACT, probe: r_e};
                ctl_t   = ctl_p;
                n_cnt   = r_cnt - 1'b1;
                n_state = r_chg ? dkq_pkg::S_INS : dkq_pkg::S_IDLE;
            end
            dkq_pkg::S_INS: begin
                ctl_p.probe = e2;
                ctl_t.probe = e2;
                if (can_emit) begin
                    ctl_p.op = dkq_pkg::OP_INS;
                    ctl_t.op = dkq_pkg::OP_INS;
                    n_cnt    = r_cnt + 1'b1;
                    emit     = 1'b1;
                    em_ev    = 1'b1;
                    em_e     = e2;
                    n_state  = dkq_pkg::S_IDLE;
                end
            end
            dkq_pkg::S_PRINT: begin
                // Emit the top and rotate it to the bottom of the chosen order.
                if (can_emit) begin
                    if (r_src) begin
                        ctl_t.op = dkq_pkg::OP_ROT;
                    end else begin
                        ctl_p.op = dkq_pkg::OP_ROT;
                    end
                    emit    = 1'b1;
                    em_ev   = 1'b1;
                    em_e    = pick_s;
                    em_last = (r_k == r_cnt - 1'b1);
                    n_k     = r_k + 1'b1;
                    if (em_last) begin
                        n_state = dkq_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = dkq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dkq_pkg::S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_src   <= 1'b0;
            r_chg   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_src   <= n_src;
            r_chg   <= n_chg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= n_e;
        r_preq <= n_preq;
        r_treq <= n_treq;
        r_npri <= n_npri;
        r_ntim <= n_ntim;
    end

    // Output register for the result beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_ost   <= em_st;
            r_oe    <= em_e;
            r_oev   <= em_ev;
            r_olast <= em_last;
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_ost;
    assign o_out.out_priority = r_oe.pri;
    assign o_out.out_time     = r_oe.tim;
    assign o_out.out_tag      = r_oe.tag;
    assign o_out.entry_valid  = r_oev;
    assign o_out.last         = r_olast;

    // The count never passes the capacity.
    `DKQ_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(DEPTH))
    // An entry being removed is present in both orders.
    `DKQ_ASSERT_IMP(a_del_both, i_clk, i_rst_n, r_state == dkq_pkg::S_DEL, found_p && found_t)
    // A result is never overwritten before it is taken.
    `DKQ_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, emit, !r_ov || o_out.ready)
    // Printing never starts on an empty queue.
    `DKQ_ASSERT_IMP(a_prt_nonempty, i_clk, i_rst_n, r_state == dkq_pkg::S_PRINT, r_cnt != '0)

endmodule
`default_nettype wire

FILE: src/dkq_cell.sv
`default_nettype none
module dkq_cell #(
    parameter bit TIME_KEY = 1'b0
) (
    input  wire logic            i_clk,
    input  wire dkq_pkg::t_ctl   i_ctl,
    input  wire logic            i_valid,
    input  wire logic            i_found,
    input  wire logic            i_less_below,
    input  wire logic            i_hit_above,
    input  wire dkq_pkg::t_entry i_d_below,
    input  wire dkq_pkg::t_entry i_d_above,
    output logic                 o_less,
    output logic                 o_hit,
    output logic                 o_sel,
    output dkq_pkg::t_entry      o_d
);

    dkq_pkg::t_entry r_d;
    dkq_pkg::t_entry n_d;
    logic            match;

    // Hit test for the topmost-hit search along the chain.
    always_comb begin
        case (i_ctl.mode)
            dkq_pkg::MODE_KEY:
                match = TIME_KEY ? (r_d.tim == i_ctl.probe.tim)
                                 : (r_d.pri == i_ctl.probe.pri);
            dkq_pkg::MODE_EXACT: match = (r_d == i_ctl.probe);
            default:             match = 1'b1;
        endcase
    end

    assign o_hit  = (i_valid && match) || i_hit_above;
    assign o_sel  = i_valid && match && !i_hit_above;
    // An entry that sorts strictly under the probe stays where it is on insert.
    assign o_less = i_valid && (TIME_KEY ? (r_d.tim > i_ctl.probe.tim)
                                         : (r_d.pri < i_ctl.probe.pri));
    assign o_d    = r_d;

    // Shift, insert or rotate from the neighbors.
    always_comb begin
        n_d = r_d;
        case (i_ctl.op)
            dkq_pkg::OP_INS: begin
                if (!o_less) begin
                    n_d = i_less_below ? i_ctl.probe : i_d_below;
                end
            end
            dkq_pkg::OP_DEL: begin
                if (i_found && !i_hit_above) begin
                    n_d = i_d_above;
                end
            end
            dkq_pkg::OP_ROT: n_d = i_d_below;
            default:         n_d = r_d;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_d <= n_d;
    end

endmodule
`default_nettype wire

FILE: src/dkq_chain.sv
`default_nettype none
module dkq_chain #(
    parameter int DEPTH    = dkq_pkg::DEPTH_DEF,
    parameter bit TIME_KEY = 1'b0
) (
    input  wire logic                       i_clk,
    input  wire dkq_pkg::t_ctl              i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_cnt,
    output dkq_pkg::t_entry                 o_pick,
    output logic                            o_found
);

    localparam int CW = $clog2(DEPTH + 1);

    dkq_pkg::t_entry d    [DEPTH];
    logic [DEPTH-1:0] less;
    logic [DEPTH-1:0] hit;
    logic [DEPTH-1:0] sel;
    logic [DEPTH-1:0] valid;

    // Row of cells; index 0 is the bottom, the top sits at count minus one.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign valid[i] = (CW'(i) < i_cnt);
        dkq_cell #(.TIME_KEY(TIME_KEY)) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_valid      (valid[i]),
            .i_found      (hit[0]),
            .i_less_below ((i == 0) ? 1'b1 : less[(i == 0) ? 0 : i-1]),
            .i_hit_above  ((i == DEPTH-1) ? 1'b0 : hit[(i == DEPTH-1) ? i : i+1]),
            .i_d_below    ((i == 0) ? o_pick : d[(i == 0) ? 0 : i-1]),
            .i_d_above    (d[(i == DEPTH-1) ? i : i+1]),
            .o_less       (less[i]),
            .o_hit        (hit[i]),
            .o_sel        (sel[i]),
            .o_d          (d[i])
        );
    end

    // The selected cell is one-hot, so an OR gathers its entry.
    always_comb begin
        o_pick = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (sel[i]) begin
                o_pick = o_pick | d[i];
            end
        end
    end

    assign o_found = hit[0];

endmodule
`default_nettype wire

FILE: tb/dual_key_sorted_process_queue_tb.sv
`default_nettype none
module dual_key_sorted_process_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dkq_pkg::*;

    localparam int QDEPTH = 64;

    // Expected result beat.
    typedef struct {
        t_status     status;
        logic [6:0]  pri;
        logic [18:0] tim;
        logic [15:0] tag;
        logic        ev;
        logic        last;
    } t_result;

    // One row of the directed table; has_exp marks a typed-in expectation.
    typedef struct {
        logic [3:0]  cmd;
        logic [6:0]  pri;
        logic [18:0] tim;
        logic [15:0] tag;
        logic [6:0]  npri;
        logic [18:0] ntim;
        logic        has_exp;
        t_status     exp_status;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    dkq_in_if  cmd_bus ();
    dkq_out_if rsp_bus ();

    dual_key_sorted_process_queue #(.DEPTH(QDEPTH)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (cmd_bus.sink),
        .o_out  (rsp_bus.source)
    );

    // Shadow copy of both sorted orders, top of each at the highest index.
    t_entry  pri_order[$];
    t_entry  tim_order[$];
    t_result pending_results[$];
    int      error_count;
    bit      stall_free;
    t_row    directed_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("dual_key_sorted_process_queue_tb: done, errors");
        $finish;
    end

    function automatic t_result make_result(t_status st, t_entry e, bit ev, bit lst);
        t_result r;
        r.status = st;
        r.pri = ev ? e.pri : '0;
        r.tim = ev ? e.tim : '0;
        r.tag = ev ? e.tag : '0;
        r.ev = ev;
        r.last = lst;
        return r;
    endfunction

    // Sorted insert: equal keys stay above, so the new entry lands below them.
    function automatic void link_shadow(t_entry e);
        int p;
        int t;
        p = 0;
        t = 0;
        while (p < pri_order.size() && pri_order[p].pri < e.pri) p++;
        while (t < tim_order.size() && tim_order[t].tim > e.tim) t++;
        pri_order.insert(p, e);
        tim_order.insert(t, e);
    endfunction

    // Remove the topmost exact match from each order.
    function automatic void unlink_shadow(t_entry e);
        for (int i = pri_order.size() - 1; i >= 0; i--) begin
            if (pri_order[i] == e) begin
                pri_order.delete(i);
                break;
            end
        end
        for (int i = tim_order.size() - 1; i >= 0; i--) begin
            if (tim_order[i] == e) begin
                tim_order.delete(i);
                break;
            end
        end
    endfunction

    // Predict the result beats that one command produces.
    function automatic void predict_queue(t_row r);
        t_entry e;
        t_entry none;
        int n;
        bit hit;
        none = '0;
        n = pri_order.size();
        if (r.cmd > CMD_PRT_TIME) return;
        if (r.cmd == CMD_ADD) begin
            if (n >= QDEPTH) begin
                pending_results.push_back(make_result(ST_FULL, none, 0, 1));
            end else begin
                e.pri = r.pri;
                e.tim = r.tim;
                e.tag = r.tag;
                link_shadow(e);
                pending_results.push_back(make_result(ST_OK, none, 0, 1));
            end
            return;
        end
        if (n == 0) begin
            pending_results.push_back(make_result(ST_EMPTY, none, 0, 1));
            return;
        end
        case (r.cmd)
            CMD_EXEC_PRI, CMD_NEXT_PRI, CMD_EXEC_TIME, CMD_NEXT_TIME: begin
                e = (r.cmd == CMD_EXEC_PRI || r.cmd == CMD_NEXT_PRI) ?
                    pri_order[n-1] : tim_order[n-1];
                if (r.cmd == CMD_EXEC_PRI || r.cmd == CMD_EXEC_TIME) unlink_shadow(e);
                pending_results.push_back(make_result(ST_OK, e, 1, 1));
            end
            CMD_CHG_PRI, CMD_CHG_TIME: begin
                hit = 0;
                for (int i = n - 1; i >= 0; i--) begin
                    if (r.cmd == CMD_CHG_PRI ? pri_order[i].pri == r.pri
                                             : tim_order[i].tim == r.tim) begin
                        e = (r.cmd == CMD_CHG_PRI) ? pri_order[i] : tim_order[i];
                        hit = 1;
                        break;
                    end
                end
                if (!hit) begin
                    pending_results.push_back(make_result(ST_NOTFOUND, none, 0, 1));
                end else begin
                    unlink_shadow(e);
                    if (r.cmd == CMD_CHG_PRI) e.pri = r.npri;
                    else e.tim = r.ntim;
                    link_shadow(e);
                    pending_results.push_back(make_result(ST_OK, e, 1, 1));
                end
            end
            default: begin
                for (int k = 0; k < n; k++) begin
                    e = (r.cmd == CMD_PRT_PRI) ? pri_order[n-1-k] : tim_order[n-1-k];
                    pending_results.push_back(make_result(ST_OK, e, 1, k == n - 1));
                end
            end
        endcase
    endfunction

    function automatic t_row mk_row(logic [3:0] c, logic [6:0] p, logic [18:0] t,
                                    logic [15:0] g, logic [6:0] np, logic [18:0] nt);
        t_row r;
        r.cmd = c;
        r.pri = p;
        r.tim = t;
        r.tag = g;
        r.npri = np;
        r.ntim = nt;
        r.has_exp = 0;
        r.exp_status = ST_OK;
        return r;
    endfunction

    function automatic t_row mk_exp(t_row r, t_status st);
        r.has_exp = 1;
        r.exp_status = st;
        return r;
    endfunction

    // Drive one command beat and wait for its acceptance; valid stays up afterwards.
    task automatic send_beat(t_row r);
        if (!stall_free) begin
            while ($urandom_range(99) < 12) begin
                cmd_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.cmd          <= r.cmd;
        cmd_bus.priority_req <= r.pri;
        cmd_bus.time_seconds <= r.tim;
        cmd_bus.tag          <= r.tag;
        cmd_bus.new_priority <= r.npri;
        cmd_bus.new_time     <= r.ntim;
        do @(posedge i_clk); while (!cmd_bus.ready);
        predict_queue(r);
        if (r.has_exp && pending_results.size() > 0 &&
            pending_results[$].status != r.exp_status) begin
            $display("%t: table status mismatch expected %0d actual prediction %0d",
                     $time, r.exp_status, pending_results[$].status);
            error_count++;
        end
    endtask

    // Drop valid and wait on the clock before anything else drives the bus.
    task automatic release_bus();
        cmd_bus.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result beat checker with random back-pressure.
    always @(posedge i_clk) begin
        t_result x;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%t: unexpected result beat, status %0d", $time, rsp_bus.status);
                    error_count++;
                end else begin
                    x = pending_results.pop_front();
                    if (rsp_bus.status !== x.status || rsp_bus.out_priority !== x.pri ||
                        rsp_bus.out_time !== x.tim || rsp_bus.out_tag !== x.tag ||
                        rsp_bus.entry_valid !== x.ev || rsp_bus.last !== x.last) begin
                        $display("%t: mismatch expected st=%0d p=%0d t=%0d g=%0d v=%0b l=%0b",
                                 $time, x.status, x.pri, x.tim, x.tag, x.ev, x.last);
                        $display("%t:          actual   st=%0d p=%0d t=%0d g=%0d v=%0b l=%0b",
                                 $time, rsp_bus.status, rsp_bus.out_priority,
                                 rsp_bus.out_time, rsp_bus.out_tag, rsp_bus.entry_valid,
                                 rsp_bus.last);
                        error_count++;
                    end
                end
            end
            rsp_bus.ready <= stall_free ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    // Random command, mostly well-formed: keys are often drawn from live entries.
    function automatic t_row random_row(int fill_bias);
        t_row r;
        int n;
        int pick;
        n = pri_order.size();
        r = mk_row(4'($urandom_range(8)), 7'($urandom_range(99)),
                   19'($urandom_range(359999)), 16'($urandom), 7'($urandom_range(99)),
                   19'($urandom_range(359999)));
        pick = $urandom_range(99);
        if (pick < fill_bias) r.cmd = CMD_ADD;
        else if (pick < fill_bias + 3) r.cmd = 4'($urandom_range(15, 9));
        if ($urandom_range(9) == 0) begin
            r.pri = 7'($urandom);
            r.tim = 19'($urandom);
            r.npri = 7'($urandom);
            r.ntim = 19'($urandom);
        end
        // Small key space in places forces duplicate keys.
        if ($urandom_range(3) == 0) begin
            r.pri = 7'($urandom_range(3));
            r.tim = 19'($urandom_range(3));
        end
        if (n > 0 && $urandom_range(3) != 0) begin
            if (r.cmd == CMD_CHG_PRI) r.pri = pri_order[$urandom_range(n - 1)].pri;
            if (r.cmd == CMD_CHG_TIME) r.tim = tim_order[$urandom_range(n - 1)].tim;
        end
        return r;
    endfunction

    initial begin
        t_row r;
        error_count = 0;
        stall_free = 0;
        i_rst_n = 1'b0;
        cmd_bus.valid = 1'b0;
        cmd_bus.cmd = CMD_ADD;
        cmd_bus.priority_req = '0;
        cmd_bus.time_seconds = '0;
        cmd_bus.tag = '0;
        cmd_bus.new_priority = '0;
        cmd_bus.new_time = '0;
        rsp_bus.ready = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty cases, extremes, every command, key miss, duplicates, unknown.
        directed_rows.push_back(mk_exp(mk_row(CMD_EXEC_PRI, 0, 0, 0, 0, 0), ST_EMPTY));
        directed_rows.push_back(mk_exp(mk_row(CMD_NEXT_TIME, 0, 0, 0, 0, 0), ST_EMPTY));
        directed_rows.push_back(mk_exp(mk_row(CMD_CHG_PRI, 0, 0, 0, 0, 0), ST_EMPTY));
        directed_rows.push_back(mk_exp(mk_row(CMD_PRT_TIME, 0, 0, 0, 0, 0), ST_EMPTY));
        directed_rows.push_back(mk_exp(mk_row(CMD_ADD, 99, 359999, 16'hFFFF, 0, 0), ST_OK));
        directed_rows.push_back(mk_exp(mk_row(CMD_ADD, 0, 0, 0, 0, 0), ST_OK));
        directed_rows.push_back(mk_exp(mk_row(CMD_ADD, 7'h7F, 19'h7FFFF, 16'h5A5A, 0, 0),
                                       ST_OK));
        directed_rows.push_back(mk_exp(mk_row(CMD_ADD, 50, 3600, 1, 0, 0), ST_OK));
        directed_rows.push_back(mk_exp(mk_row(CMD_ADD, 50, 3600, 2, 0, 0), ST_OK));
        directed_rows.push_back(mk_row(CMD_NEXT_PRI, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(CMD_NEXT_TIME, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(CMD_PRT_PRI, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(CMD_PRT_TIME, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_exp(mk_row(CMD_CHG_PRI, 77, 0, 0, 1, 0), ST_NOTFOUND));
        directed_rows.push_back(mk_exp(mk_row(CMD_CHG_TIME, 0, 77, 0, 0, 1), ST_NOTFOUND));
        directed_rows.push_back(mk_row(CMD_CHG_PRI, 50, 0, 0, 7'h7F, 0));
        directed_rows.push_back(mk_row(CMD_CHG_TIME, 0, 3600, 0, 0, 60));
        directed_rows.push_back(mk_row(4'd9, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(4'd15, 7'h7F, 19'h7FFFF, 16'hFFFF, 7'h7F, 19'h7FFFF));
        directed_rows.push_back(mk_row(CMD_EXEC_PRI, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(CMD_EXEC_TIME, 0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(CMD_PRT_PRI, 0, 0, 0, 0, 0));
        foreach (directed_rows[i]) send_beat(directed_rows[i]);

        // Fill to capacity, hit the full case, and print the full queue.
        while (pri_order.size() < QDEPTH) send_beat(random_row(100));
        send_beat(mk_exp(mk_row(CMD_ADD, 1, 1, 1, 0, 0), ST_FULL));
        send_beat(mk_row(CMD_PRT_TIME, 0, 0, 0, 0, 0));

        // Hold the sender until the queue of results drains.
        release_bus();
        while (pending_results.size() != 0) @(posedge i_clk);

        // Drain with execs so empty is reached again.
        while (pri_order.size() > 0) send_beat(mk_row($urandom_range(1) ? CMD_EXEC_PRI
                                                      : CMD_EXEC_TIME, 0, 0, 0, 0, 0));

        // Random part, with a stretch free of stalls in the middle.
        for (int k = 0; k < 80; k++) begin
            stall_free = (k >= 30 && k < 60);
            send_beat(random_row(pri_order.size() < 8 ? 45 : 25));
        end
        stall_free = 0;
        release_bus();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("dual_key_sorted_process_queue_tb: done, clean");
        end else begin
            $display("dual_key_sorted_process_queue_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/dkq_pkg.sv
src/dkq_in_if.sv
src/dkq_out_if.sv
src/dkq_cell.sv
src/dkq_chain.sv
src/dual_key_sorted_process_queue.sv
tb/dual_key_sorted_process_queue_tb.sv
